[hw/rtl/osti_pkg.sv]
`timescale 1ns / 1ps

package osti_pkg;

    localparam int MAX_SPLITS   = 126;
    localparam int PTR_W        = 1;
    localparam int QUEUE_DEPTH  = 2 ** PTR_W;
    localparam int CNT_W        = PTR_W + 1;

    // One classified cell waiting for the back end.
    typedef struct packed {
        logic signed [9:0] row;
        logic signed [9:0] col;
        logic [7:0]        m;
        logic [15:0]       four_msq;
        logic              invalid;
        logic              same_sign;
    } osti_entry_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } osti_phase_t;

endpackage

[hw/rtl/osti_front.sv]
`timescale 1ns / 1ps

module osti_front
    import osti_pkg::*;
(
    input  logic              start,
    input  logic              queue_full,
    input  logic [6:0]        split_count,
    input  logic signed [7:0] cell_row,
    input  logic signed [7:0] cell_col,
    output logic              push,
    output osti_entry_t       entry
);

    logic [6:0]        splits_sat;
    logic [7:0]        m;
    logic signed [9:0] sm;
    logic signed [9:0] row_ext;
    logic signed [9:0] col_ext;
    logic [15:0]       m_sq;

    assign push       = start && !queue_full;
    assign splits_sat = (split_count > 7'(MAX_SPLITS)) ? 7'(MAX_SPLITS) : split_count;
    assign m          = {1'b0, splits_sat} + 8'd1;
    assign sm         = {2'b00, m};
    assign row_ext    = 10'(cell_row);
    assign col_ext    = 10'(cell_col);
    assign m_sq       = 16'(m) * 16'(m);

    always_comb
    begin
        entry.row       = row_ext;
        entry.col       = col_ext;
        entry.m         = m;
        entry.four_msq  = {m_sq[13:0], 2'b00};
        entry.invalid   = (row_ext < -sm) || (row_ext >= sm) ||
                          (col_ext < -sm) || (col_ext >= sm);
        entry.same_sign = (row_ext[9] == col_ext[9]);
    end

endmodule

[hw/rtl/osti_queue.sv]
`timescale 1ns / 1ps

module osti_queue
    import osti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  osti_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output osti_entry_t head
);

    osti_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule

[hw/rtl/osti_back.sv]
`timescale 1ns / 1ps

module osti_back
    import osti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_valid,
    input  osti_entry_t entry,
    output logic        pop,
    output logic        done,
    output logic [15:0] vertex_first,
    output logic [15:0] vertex_second,
    output logic [15:0] vertex_third,
    output logic        last_of_cell,
    output logic        cell_invalid
);

    // Folds boundary grid points onto the packed layout.
    function automatic logic [15:0] fold_index(
        input logic signed [9:0] i,
        input logic signed [9:0] j,
        input logic [7:0]        m,
        input logic [15:0]       fmsq
    );
        logic signed [9:0] sm;
        logic signed [9:0] a;
        logic signed [9:0] b;
        logic signed [9:0] a_off;
        logic signed [9:0] b_off;
        logic [16:0]       prod;
        logic [15:0]       r;
        logic              special;
        sm      = {2'b00, m};
        a       = i;
        b       = j;
        special = 1'b0;
        r       = '0;
        if (i == -sm)
        begin
            if (j == -sm || j == sm)
                special = 1'b1;
            else if (j > 0)
                b = -j;
        end
        else if (i == sm)
        begin
            if (j == -sm || j == sm)
                special = 1'b1;
            else if (j == 0)
            begin
                special = 1'b1;
                r       = fmsq + 16'd1;
            end
            else
            begin
                a = -sm;
                b = (j < 0) ? -j : j;
            end
        end
        else if (j == -sm)
        begin
            if (i > 0)
                a = -i;
        end
        else if (j == sm)
        begin
            if (i == 0)
            begin
                special = 1'b1;
                r       = fmsq;
            end
            else
            begin
                a = (i < 0) ? -i : i;
                b = -sm;
            end
        end
        a_off = a + sm;
        b_off = b + sm;
        prod  = 17'(a_off[7:0]) * 17'({m, 1'b0});
        if (!special)
            r = prod[15:0] + 16'(b_off[7:0]);
        return r;
    endfunction

    osti_phase_t       phase_reg;
    osti_phase_t       phase_next;
    logic              emit;
    logic              emit_last;
    logic              second;
    logic [1:0]        d1;
    logic [1:0]        d2;
    logic [1:0]        d3;
    logic [15:0]       p1;
    logic [15:0]       p2;
    logic [15:0]       p3;

    logic              done_reg;
    logic [15:0]       v1_reg;
    logic [15:0]       v2_reg;
    logic [15:0]       v3_reg;
    logic              last_reg;
    logic              bad_reg;

    assign second = (phase_reg == PH_SECOND);

    always_comb
    begin
        phase_next = phase_reg;
        emit       = 1'b0;
        emit_last  = 1'b0;
        pop        = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (entry_valid)
                begin
                    emit = 1'b1;
                    if (entry.invalid)
                    begin
                        emit_last = 1'b1;
                        pop       = 1'b1;
                    end
                    else
                        phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                pop        = 1'b1;
                phase_next = PH_FIRST;
            end
            default:
                phase_next = PH_FIRST;
        endcase
    end

    // Vertex offsets {di, dj} per slot, by diagonal orientation and triangle.
    always_comb
    begin
        if (entry.same_sign)
        begin
            d1 = second ? 2'b01 : 2'b00;
            d2 = 2'b10;
            d3 = second ? 2'b11 : 2'b01;
        end
        else
        begin
            d1 = 2'b00;
            d2 = second ? 2'b11 : 2'b10;
            d3 = second ? 2'b01 : 2'b11;
        end
    end

    assign p1 = fold_index(entry.row + 10'(d1[1]), entry.col + 10'(d1[0]),
                           entry.m, entry.four_msq);
    assign p2 = fold_index(entry.row + 10'(d2[1]), entry.col + 10'(d2[0]),
                           entry.m, entry.four_msq);
    assign p3 = fold_index(entry.row + 10'(d3[1]), entry.col + 10'(d3[0]),
                           entry.m, entry.four_msq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            v1_reg   <= entry.invalid ? '0 : p1;
            v2_reg   <= entry.invalid ? '0 : p2;
            v3_reg   <= entry.invalid ? '0 : p3;
            last_reg <= emit_last;
            bad_reg  <= entry.invalid;
        end
    end

    assign done          = done_reg;
    assign vertex_first  = v1_reg;
    assign vertex_second = v2_reg;
    assign vertex_third  = v3_reg;
    assign last_of_cell  = last_reg;
    assign cell_invalid  = bad_reg;

    a_second_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SECOND |-> entry_valid && !entry.invalid)
        else $error("second triangle without a valid cell at the head");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_of_cell |=> done && last_of_cell && !cell_invalid)
        else $error("first triangle not followed by the second");

endmodule

[hw/rtl/octahedral_sphere_triangle_indices.sv]
`timescale 1ns / 1ps

// Triangle index generator for one cell of an unfolded octahedral sphere grid.
// Input: a cell (cell_row, cell_col) is taken at a clock edge where start is
// high and busy is low. busy rises only when the two-entry cell queue is full.
// Output: each triangle appears for one cycle with done high. A valid cell
// gives two triangles on consecutive cycles, the second with last_of_cell set;
// an out-of-range cell gives one all-zero triangle with cell_invalid and
// last_of_cell set. The receiver cannot stall the block.
// Path: with the queue empty, an accepted cell is written into a queue slot,
// read at the queue head by the back end, and registered onto the ports.
// Flow: while it holds a cell, the back end drives the single result channel
// one triangle per cycle, two per valid cell and one per invalid cell; up to two
// valid cells can be taken back to back while the queue fills.
// Configuration: cfg_we writes split_count from cfg_wdata (saturated to 126 where used);
// write it only while the block is idle.
// Reset: rst_n clears split_count to 0, empties the queue and drops done.
module octahedral_sphere_triangle_indices
    import osti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] cell_row,
    input  logic signed [7:0] cell_col,
    output logic              done,
    output logic [15:0]       vertex_first,
    output logic [15:0]       vertex_second,
    output logic [15:0]       vertex_third,
    output logic              last_of_cell,
    output logic              cell_invalid
);

    logic [6:0]  split_count_reg;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        head_valid;
    osti_entry_t push_entry;
    osti_entry_t head_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            split_count_reg <= '0;
        else if (cfg_we)
            split_count_reg <= cfg_wdata;
    end

    assign busy = queue_full;

    osti_front u_front (
        .start       (start),
        .queue_full  (queue_full),
        .split_count (split_count_reg),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .push        (push),
        .entry       (push_entry)
    );

    osti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (head_valid),
        .head       (head_entry)
    );

    osti_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (head_valid),
        .entry         (head_entry),
        .pop           (pop),
        .done          (done),
        .vertex_first  (vertex_first),
        .vertex_second (vertex_second),
        .vertex_third  (vertex_third),
        .last_of_cell  (last_of_cell),
        .cell_invalid  (cell_invalid)
    );

endmodule

[tb/tb_octahedral_sphere_triangle_indices.sv]
`timescale 1ns / 1ps

module tb_octahedral_sphere_triangle_indices;

    typedef struct {
        logic signed [7:0] row;
        logic signed [7:0] col;
        bit                drain;   // hold off until all triangles are back
    } cell_req_t;

    typedef struct {
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
        logic        last;
        logic        invalid;
    } triangle_t;

    localparam int RANDOM_CELLS = 750;
    localparam int SETTLE_CYCLES = 6;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [6:0]        cfg_wdata = '0;
    logic              start = 1'b0;
    logic signed [7:0] cell_row = '0;
    logic signed [7:0] cell_col = '0;
    logic              busy;
    logic              done;
    logic [15:0]       vertex_first;
    logic [15:0]       vertex_second;
    logic [15:0]       vertex_third;
    logic              last_of_cell;
    logic              cell_invalid;

    cell_req_t pending_cells[$];
    triangle_t expected_tris[$];
    cell_req_t next_cell;
    logic [6:0] split_setting = '0;
    int        mismatch_count = 0;
    int        burst_left = 4;
    int        gap_left = 0;

    octahedral_sphere_triangle_indices u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .done          (done),
        .vertex_first  (vertex_first),
        .vertex_second (vertex_second),
        .vertex_third  (vertex_third),
        .last_of_cell  (last_of_cell),
        .cell_invalid  (cell_invalid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // grid half-size for the current split setting
    function automatic int grid_m();
        int s;
        s = (split_setting > osti_pkg::MAX_SPLITS) ? osti_pkg::MAX_SPLITS : split_setting;
        return s + 1;
    endfunction

    function automatic int flat_slot(int i, int j, int m);
        return (i + m) * m * 2 + j + m;
    endfunction

    // fold boundary grid points onto the packed 2M x 2M layout
    function automatic logic [15:0] fold_vertex(int i, int j, int m);
        int r;
        if (i == -m) begin
            if (j == -m || j == m)
                r = 0;
            else if (j > 0)
                r = flat_slot(i, -j, m);
            else
                r = flat_slot(i, j, m);
        end
        else if (i == m) begin
            if (j == -m || j == m)
                r = 0;
            else if (j == 0)
                r = 4 * m * m + 1;
            else if (j < 0)
                r = flat_slot(-m, -j, m);
            else
                r = flat_slot(-m, j, m);
        end
        else if (j == -m) begin
            r = (i > 0) ? flat_slot(-i, j, m) : flat_slot(i, j, m);
        end
        else if (j == m) begin
            if (i == 0)
                r = 4 * m * m;
            else if (i < 0)
                r = flat_slot(-i, -m, m);
            else
                r = flat_slot(i, -m, m);
        end
        else begin
            r = flat_slot(i, j, m);
        end
        return r[15:0];
    endfunction

    task automatic predict_cell(input logic signed [7:0] row, input logic signed [7:0] col);
        int m;
        int i;
        int j;
        logic [15:0] p00;
        logic [15:0] p10;
        logic [15:0] p01;
        logic [15:0] p11;
        m = grid_m();
        i = row;
        j = col;
        if (i < -m || i >= m || j < -m || j >= m) begin
            expected_tris.push_back('{16'd0, 16'd0, 16'd0, 1'b1, 1'b1});
        end
        else begin
            p00 = fold_vertex(i, j, m);
            p10 = fold_vertex(i + 1, j, m);
            p01 = fold_vertex(i, j + 1, m);
            p11 = fold_vertex(i + 1, j + 1, m);
            // diagonal follows the quadrant
            if ((i < 0 && j < 0) || (i >= 0 && j >= 0)) begin
                expected_tris.push_back('{p00, p10, p01, 1'b0, 1'b0});
                expected_tris.push_back('{p01, p10, p11, 1'b1, 1'b0});
            end
            else begin
                expected_tris.push_back('{p00, p10, p11, 1'b0, 1'b0});
                expected_tris.push_back('{p00, p11, p01, 1'b1, 1'b0});
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // driver: presents cells in bursts, holds while busy
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                predict_cell(cell_row, cell_col);
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cells.size() != 0 &&
                         !(pending_cells[0].drain && expected_tris.size() != 0)) begin
                    next_cell = pending_cells.pop_front();
                    start <= 1'b1;
                    cell_row <= next_cell.row;
                    cell_col <= next_cell.col;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(5, 20);
                            default: gap_left = $urandom_range(1, 3);
                        endcase
                    end
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed triangle is checked against the oldest prediction
    always @(posedge clk)
    begin
        triangle_t want;
        if (rst_n && done) begin
            if (expected_tris.size() == 0) begin
                report_mismatch("unexpected triangle, vertex_first", vertex_first, -1);
            end
            else begin
                want = expected_tris.pop_front();
                if (vertex_first !== want.v0)
                    report_mismatch("vertex_first", vertex_first, want.v0);
                if (vertex_second !== want.v1)
                    report_mismatch("vertex_second", vertex_second, want.v1);
                if (vertex_third !== want.v2)
                    report_mismatch("vertex_third", vertex_third, want.v2);
                if (last_of_cell !== want.last)
                    report_mismatch("last_of_cell", last_of_cell, want.last);
                if (cell_invalid !== want.invalid)
                    report_mismatch("cell_invalid", cell_invalid, want.invalid);
            end
        end
    end

    task automatic push_cell(input int row, input int col, input bit drain);
        cell_req_t c;
        c.row = 8'(row);
        c.col = 8'(col);
        c.drain = drain;
        pending_cells.push_back(c);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cells.size() != 0 || start || expected_tris.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_splits(input logic [6:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        split_setting = value;
    endtask

    // mostly in-range coordinates, biased to the grid border, some outside
    function automatic int pick_coord(int m);
        case ($urandom_range(0, 13))
            0: return $urandom_range(0, 255);
            1: return -m;
            2: return m - 1;
            3: return m;
            4: return -m - 1;
            default: return $urandom_range(0, 2 * m - 1) - m;
        endcase
    endfunction

    task automatic add_random_cells(input int count);
        int m;
        m = grid_m();
        for (int n = 0; n < count; n++)
            push_cell(pick_coord(m), pick_coord(m), (n == count / 2) || ($urandom_range(0, 49) == 0));
    endtask

    initial
    begin
        logic [6:0] phase_splits[8];
        phase_splits = '{7'd0, 7'd1, 7'd127, 7'd126, 7'd2, 7'd63,
                         7'($urandom_range(3, 30)), 7'($urandom_range(0, 127))};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset value: M = 1, every cell of the smallest grid
        push_cell(-1, -1, 1'b0);
        push_cell(-1, 0, 1'b0);
        push_cell(0, -1, 1'b0);
        push_cell(0, 0, 1'b0);
        push_cell(1, 0, 1'b0);
        push_cell(-2, -1, 1'b0);
        push_cell(0, 1, 1'b0);
        push_cell(-1, -2, 1'b0);
        push_cell(-128, 127, 1'b0);
        push_cell(127, -128, 1'b0);
        wait_drained();

        // split count above the maximum saturates: largest grid corners, centre cells and cells outside
        write_splits(7'd127);
        push_cell(-127, -127, 1'b0);
        push_cell(-127, 126, 1'b0);
        push_cell(126, -127, 1'b0);
        push_cell(126, 126, 1'b0);
        push_cell(-1, 0, 1'b0);
        push_cell(0, -1, 1'b0);
        push_cell(0, 0, 1'b1);
        push_cell(127, 127, 1'b0);
        push_cell(-128, -128, 1'b0);
        wait_drained();

        foreach (phase_splits[p]) begin
            write_splits(phase_splits[p]);
            add_random_cells(RANDOM_CELLS / 8);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
